[hdl/sle_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted list engine package
// Shared sizes, codes and the command struct that is broadcast to every cell.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int POS_W    = 4;
   localparam int ECNT_W   = 5;

   typedef enum logic [1:0] {
      ACT_INSERT  = 2'd0,
      ACT_DEL_POS = 2'd1,
      ACT_DEL_KEY = 2'd2,
      ACT_READ    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_INVALID  = 2'd1,
      STS_NOTFOUND = 2'd2,
      STS_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EVAL  = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   typedef struct packed {
      action_type               action;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
      logic [CNT_W-1:0]         count;
      logic                     eval_en;
      logic                     apply_en;
      logic                     ok;
   } cmd_type;

endpackage

[hdl/sle_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request item into the list engine.
// ----------------------------------------------------------------------------
interface sle_req_if;

   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [31:0] value;
   logic [3:0]         position;

   modport source (output valid, output action, output value, output position,
                   input ready);
   modport sink (input valid, input action, input value, input position,
                 output ready);

endinterface

[hdl/sle_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result item out of the list engine.
// ----------------------------------------------------------------------------
interface sle_rsp_if;

   logic               valid;
   logic               ready;
   logic signed [31:0] data;
   logic [3:0]         found_position;
   logic [1:0]         status;
   logic [4:0]         entry_count;

   modport source (output valid, output data, output found_position,
                   output status, output entry_count, input ready);
   modport sink (input valid, input data, input found_position,
                 input status, input entry_count, output ready);

endinterface

[hdl/sle_cell.sv]
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one entry. In the evaluate cycle it compares its entry with the
// broadcast request and its left neighbor's flags; in the apply cycle it
// takes the new value or shifts from a neighbor.
// ----------------------------------------------------------------------------
module sle_cell (
   input  logic                             clock,
   input  sle_pkg::cmd_type                 cmd,
   input  logic [sle_pkg::IDX_W-1:0]        idx,
   input  logic signed [sle_pkg::DATA_W-1:0] left_entry,
   input  logic signed [sle_pkg::DATA_W-1:0] right_entry,
   input  logic                             left_le,
   input  logic                             left_match,
   output logic signed [sle_pkg::DATA_W-1:0] entry,
   output logic                             le,
   output logic                             match,
   output logic                             hit
);
   import sle_pkg::*;

   logic signed [DATA_W-1:0] entry_ff, entry_in;
   logic                     sel_ff, sel_in;
   logic                     mov_ff, mov_in;
   logic                     occ, ge, at_pos, past_pos;

   assign occ      = 32'(idx) < 32'(cmd.count);
   assign le       = occ && !(cmd.value < entry_ff);
   assign ge       = occ && !(entry_ff < cmd.value);
   assign match    = occ && (entry_ff == cmd.value);
   assign at_pos   = occ && (32'(idx) == 32'(cmd.position));
   assign past_pos = occ && (32'(idx) >= 32'(cmd.position));

   always_comb begin
      sel_in   = sel_ff;
      mov_in   = mov_ff;
      entry_in = entry_ff;
      if (cmd.eval_en) begin
         unique case (cmd.action) inside
            ACT_INSERT: begin
               sel_in = left_le && !le;
               mov_in = !left_le;
            end
            ACT_DEL_KEY: begin
               sel_in = match && !left_match;
               mov_in = ge;
            end
            ACT_DEL_POS, ACT_READ: begin
               sel_in = at_pos;
               mov_in = past_pos;
            end
            default: begin
               sel_in = 1'b0;
               mov_in = 1'b0;
            end
         endcase
      end
      if (cmd.apply_en && cmd.ok) begin
         case (cmd.action) inside
            ACT_INSERT: begin
               if (sel_ff) begin
                  entry_in = cmd.value;
               end else if (mov_ff) begin
                  entry_in = left_entry;
               end
            end
            ACT_DEL_POS, ACT_DEL_KEY: begin
               if (mov_ff) begin
                  entry_in = right_entry;
               end
            end
            default: entry_in = entry_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      sel_ff   <= sel_in;
      mov_ff   <= mov_in;
   end

   assign entry = entry_ff;
   assign hit   = sel_ff;

endmodule

[hdl/sorted_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// Sorted list engine
// A result item is registered as the apply state completes, after the evaluate
// state; apply waits while the previous result item is not yet taken. A request
// item goes through accept, evaluate and apply before the next is accepted.
// Reset: the entry count clears to zero; entry storage is not cleared.
// Keeps up to CAPACITY signed values in ascending order in a row of cells.
// ----------------------------------------------------------------------------
module sorted_list_engine_unit (
   input logic  clock,
   input logic  reset,
   sle_req_if.sink   req_if,
   sle_rsp_if.source rsp_if
);
   import sle_pkg::*;

   state_type                state_ff, state_in;
   action_type               act_ff;
   logic signed [DATA_W-1:0] val_ff;
   logic [POS_W-1:0]         pos_ff;
   logic [CNT_W-1:0]         count_ff, count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]         rsp_found_ff, rsp_found_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [ECNT_W-1:0]        rsp_count_ff, rsp_count_in;

   cmd_type                  cmd;
   status_type               status;
   logic                     ok, out_free, apply_go, accept;
   logic [IDX_W-1:0]         enc_idx;
   logic signed [DATA_W-1:0] sel_data;

   logic signed [DATA_W-1:0] entry_vec [CAPACITY];
   logic signed [DATA_W-1:0] left_vec  [CAPACITY];
   logic signed [DATA_W-1:0] right_vec [CAPACITY];
   logic [CAPACITY-1:0]      le_vec, match_vec, hit_vec, lle_vec, lmatch_vec;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign apply_go = (state_ff == ST_APPLY) && out_free;
   assign req_if.ready = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      status = STS_OK;
      case (act_ff) inside
         ACT_INSERT: begin
            if (32'(count_ff) >= CAPACITY) begin
               status = STS_FULL;
            end
         end
         ACT_DEL_KEY: begin
            if (hit_vec == '0) begin
               status = STS_NOTFOUND;
            end
         end
         ACT_DEL_POS, ACT_READ: begin
            if (32'(pos_ff) >= 32'(count_ff)) begin
               status = STS_INVALID;
            end
         end
         default: status = STS_OK;
      endcase
   end

   assign ok = (status == STS_OK);

   assign cmd.action   = act_ff;
   assign cmd.value    = val_ff;
   assign cmd.position = pos_ff;
   assign cmd.count    = count_ff;
   assign cmd.eval_en  = (state_ff == ST_EVAL);
   assign cmd.apply_en = apply_go;
   assign cmd.ok       = ok;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_vec[i]   = val_ff;
         assign lle_vec[i]    = 1'b1;
         assign lmatch_vec[i] = 1'b0;
      end else begin : g_rest
         assign left_vec[i]   = entry_vec[i-1];
         assign lle_vec[i]    = le_vec[i-1];
         assign lmatch_vec[i] = match_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_vec[i] = val_ff;
      end else begin : g_inner
         assign right_vec[i] = entry_vec[i+1];
      end

      sle_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .idx         (IDX_W'(i)),
         .left_entry  (left_vec[i]),
         .right_entry (right_vec[i]),
         .left_le     (lle_vec[i]),
         .left_match  (lmatch_vec[i]),
         .entry       (entry_vec[i]),
         .le          (le_vec[i]),
         .match       (match_vec[i]),
         .hit         (hit_vec[i])
      );
   end

   always_comb begin
      enc_idx  = '0;
      sel_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (hit_vec[i]) begin
            enc_idx  = enc_idx | IDX_W'(i);
            sel_data = sel_data | entry_vec[i];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_if.valid) state_in = ST_EVAL;
         ST_EVAL:  state_in = ST_APPLY;
         ST_APPLY: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (apply_go && ok) begin
         case (act_ff) inside
            ACT_INSERT:               count_in = count_ff + CNT_W'(1);
            ACT_DEL_POS, ACT_DEL_KEY: count_in = count_ff - CNT_W'(1);
            default:                  count_in = count_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (apply_go) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = (ok && act_ff != ACT_INSERT) ? sel_data : '0;
         rsp_found_in  = ok ? POS_W'(enc_idx) : '0;
         rsp_status_in = status;
         rsp_count_in  = ECNT_W'(count_in);
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= action_type'(req_if.action);
         val_ff <= req_if.value;
         pos_ff <= req_if.position;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.data           = rsp_data_ff;
   assign rsp_if.found_position = rsp_found_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.entry_count    = rsp_count_ff;

`ifndef NO_ASSERTIONS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY)
      else $error("entry count exceeds capacity");

   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> $onehot0(hit_vec))
      else $error("more than one cell selected");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (apply_go && ok && act_ff == ACT_INSERT)
      |=> 32'(count_ff) == 32'($past(count_ff)) + 1)
      else $error("insert did not grow the list");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      apply_go |=> rsp_count_ff == ECNT_W'(count_ff))
      else $error("reported count differs from stored count");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine testbench
// Drives insert, delete and read request items into the list engine and checks
// every response item against a sorted shadow list or a typed result. A short table
// of directed items covers the empty list, the extreme values, equal values,
// the full list and the emptying of the list. Random sequences with shifting
// insert and delete mixes follow. Random idling on both channels and one long
// response hold-off keep the handshakes under pressure.
// ----------------------------------------------------------------------------
module tb;

   import sle_pkg::*;

   localparam int RANDOM_ITEMS = 1660;
   localparam int CALM_TAIL    = 200;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 400000;

   typedef logic signed [DATA_W-1:0] word_t;

   localparam word_t WORD_MAX = 32'sh7FFFFFFF;
   localparam word_t WORD_MIN = 32'sh80000000;

   typedef struct packed {
      word_t             data;
      logic [POS_W-1:0]  found_position;
      status_type        status;
      logic [ECNT_W-1:0] entry_count;
   } list_result_t;

   typedef struct {
      action_type       action;
      word_t            value;
      logic [POS_W-1:0] position;
      int               reps;
      bit               random_value;
      bit               typed;
      list_result_t     result;
   } plan_row_t;

   logic clock = 1'b0;
   logic reset;

   sle_req_if req_ch ();
   sle_rsp_if rsp_ch ();

   word_t        shadow_list[$];
   list_result_t awaited_responses[$];
   plan_row_t    directed_plan[$];

   int mismatches     = 0;
   int cycle_count    = 0;
   bit idling_on      = 1'b1;
   bit calm           = 1'b0;
   bit hold_requested = 1'b0;
   bit hold_served    = 1'b0;

   sorted_list_engine_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #1 clock = ~clock;

   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_list_engine_unit regression: fail");
         $finish;
      end
   end

   function automatic list_result_t apply_list_request(action_type act, word_t val,
                                                       logic [POS_W-1:0] pos);
      list_result_t r;
      int           at;
      int           hit;
      r.data           = '0;
      r.found_position = '0;
      r.status         = STS_OK;
      case (act)
         ACT_INSERT: begin
            if (shadow_list.size() >= CAPACITY) begin
               r.status = STS_FULL;
            end else begin
               at = 0;
               while (at < shadow_list.size() && !(val < shadow_list[at]))
                  at++;
               shadow_list.insert(at, val);
               r.found_position = POS_W'(at);
            end
         end
         ACT_DEL_POS, ACT_READ: begin
            if (pos >= shadow_list.size()) begin
               r.status = STS_INVALID;
            end else begin
               r.data           = shadow_list[pos];
               r.found_position = pos;
               if (act == ACT_DEL_POS)
                  shadow_list.delete(pos);
            end
         end
         default: begin
            hit = -1;
            foreach (shadow_list[i])
               if (hit < 0 && shadow_list[i] == val)
                  hit = i;
            if (hit < 0) begin
               r.status = STS_NOTFOUND;
            end else begin
               r.data           = shadow_list[hit];
               r.found_position = POS_W'(hit);
               shadow_list.delete(hit);
            end
         end
      endcase
      r.entry_count = ECNT_W'(shadow_list.size());
      return r;
   endfunction

   function automatic plan_row_t typed_row(action_type act, word_t val, logic [POS_W-1:0] pos,
                                           word_t data, logic [POS_W-1:0] found,
                                           status_type st, logic [ECNT_W-1:0] cnt);
      plan_row_t row;
      row.action                = act;
      row.value                 = val;
      row.position              = pos;
      row.reps                  = 1;
      row.random_value          = 1'b0;
      row.typed                 = 1'b1;
      row.result.data           = data;
      row.result.found_position = found;
      row.result.status         = st;
      row.result.entry_count    = cnt;
      return row;
   endfunction

   function automatic plan_row_t predicted_row(action_type act, word_t val,
                                               logic [POS_W-1:0] pos, int reps, bit rnd);
      plan_row_t row;
      row              = typed_row(act, val, pos, '0, '0, STS_OK, '0);
      row.reps         = reps;
      row.random_value = rnd;
      row.typed        = 1'b0;
      return row;
   endfunction

   function automatic word_t pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         return WORD_MAX;
      if (sel == 1)
         return WORD_MIN;
      if (sel < 5)
         return word_t'($urandom_range(0, 7)) - 4;
      return word_t'($urandom);
   endfunction

   task automatic send_request(input action_type act, input word_t val,
                               input logic [POS_W-1:0] pos, input bit typed,
                               input list_result_t typed_result);
      int           gap;
      list_result_t predicted;
      gap = 0;
      if (!calm && idling_on && $urandom_range(0, 5) == 0)
         gap = $urandom_range(1, 15);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.action   <= act;
      req_ch.value    <= val;
      req_ch.position <= pos;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = apply_list_request(act, val, pos);
      awaited_responses.push_back(typed ? typed_result : predicted);
   endtask

   initial begin
      int               insert_bias;
      action_type       act;
      word_t            val;
      logic [POS_W-1:0] pos;
      plan_row_t        row;
      req_ch.valid    = 1'b0;
      req_ch.action   = ACT_INSERT;
      req_ch.value    = '0;
      req_ch.position = '0;
      directed_plan = '{
         typed_row(ACT_READ, 0, 0, 0, 0, STS_INVALID, 0),
         typed_row(ACT_DEL_POS, 0, 15, 0, 0, STS_INVALID, 0),
         typed_row(ACT_DEL_KEY, 0, 0, 0, 0, STS_NOTFOUND, 0),
         typed_row(ACT_INSERT, WORD_MAX, 15, 0, 0, STS_OK, 1),
         typed_row(ACT_INSERT, WORD_MIN, 0, 0, 0, STS_OK, 2),
         typed_row(ACT_INSERT, 0, 0, 0, 1, STS_OK, 3),
         typed_row(ACT_INSERT, 0, 0, 0, 2, STS_OK, 4),
         typed_row(ACT_INSERT, -1, 0, 0, 1, STS_OK, 5),
         predicted_row(ACT_INSERT, 0, 0, 11, 1'b1),
         typed_row(ACT_INSERT, 5, 0, 0, 0, STS_FULL, 16),
         typed_row(ACT_READ, 0, 15, WORD_MAX, 15, STS_OK, 16),
         typed_row(ACT_READ, 0, 0, WORD_MIN, 0, STS_OK, 16),
         predicted_row(ACT_DEL_POS, 0, 15, 1, 1'b0),
         predicted_row(ACT_DEL_KEY, -1, 0, 1, 1'b0),
         predicted_row(ACT_DEL_KEY, 32'sh12345678, 0, 1, 1'b0),
         predicted_row(ACT_READ, 0, 14, 1, 1'b0),
         predicted_row(ACT_DEL_POS, 0, 0, 16, 1'b0),
         typed_row(ACT_READ, 0, 0, 0, 0, STS_INVALID, 0)
      };
      @(negedge reset);
      foreach (directed_plan[n]) begin
         row = directed_plan[n];
         repeat (row.reps)
            send_request(row.action, row.random_value ? word_t'($urandom) : row.value,
                         row.position, row.typed, row.result);
      end

      insert_bias = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) begin
            insert_bias = $urandom_range(20, 85);
            idling_on   = ($urandom_range(0, 3) != 0);
         end
         if (n == 300)
            hold_requested = 1'b1;
         if (n == RANDOM_ITEMS - CALM_TAIL)
            calm = 1'b1;
         pos = POS_W'($urandom_range(0, 15));
         val = pick_value();
         if ($urandom_range(0, 99) < insert_bias) begin
            act = ACT_INSERT;
         end else begin
            case ($urandom_range(0, 2))
               0: act = ACT_DEL_POS;
               1: act = ACT_DEL_KEY;
               default: act = ACT_READ;
            endcase
            if (shadow_list.size() > 0 && $urandom_range(0, 3) != 0) begin
               pos = POS_W'($urandom_range(0, shadow_list.size() - 1));
               if (act == ACT_DEL_KEY)
                  val = shadow_list[pos];
            end
         end
         send_request(act, val, pos, 1'b0, '0);
      end
      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("sorted_list_engine_unit regression: pass");
      else
         $display("sorted_list_engine_unit regression: fail");
      $finish;
   end

   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_requested && !hold_served) begin
            hold_served = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_responses
      list_result_t want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (awaited_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response item: data %0d pos %0d status %0d count %0d",
                        rsp_ch.data, rsp_ch.found_position, rsp_ch.status,
                        rsp_ch.entry_count);
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_ch.data !== want.data || rsp_ch.found_position !== want.found_position ||
                rsp_ch.status !== want.status || rsp_ch.entry_count !== want.entry_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"response mismatch: expected data %0d pos %0d status %0d ",
                            "count %0d, got data %0d pos %0d status %0d count %0d"},
                           want.data, want.found_position, want.status, want.entry_count,
                           rsp_ch.data, rsp_ch.found_position, rsp_ch.status,
                           rsp_ch.entry_count);
            end
         end
      end
   end

endmodule

[filelist.f]
hdl/sle_pkg.sv
hdl/sle_req_if.sv
hdl/sle_rsp_if.sv
hdl/sle_cell.sv
hdl/sorted_list_engine_unit.sv
tb/tb.sv
